// ===== sv/sst_pkg.sv =====
// shared types and constants for the small set table
package sst_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;

    typedef enum logic [1:0] {
        KIND_ADD      = 2'd0,
        KIND_REMOVE   = 2'd1,
        KIND_CONTAINS = 2'd2,
        KIND_LIST     = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_ADDED    = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_FULL     = 3'd2,
        ST_REMOVED  = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_FOUND    = 3'd5,
        ST_ELEMENT  = 3'd6,
        ST_EMPTY    = 3'd7
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic take_req;     // latch the incoming request, clear list index
        logic emit_result;  // apply the request and load its single result
        logic emit_list;    // load the entry at the list index
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_list;
        logic empty;
        logic idx_last;
    } sts_t;

endpackage

// ===== sv/sst_ctrl.sv =====
// controller state machine for the small set table
module sst_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output sst_pkg::cmd_t cmd,
    input  sst_pkg::sts_t sts
);
    import sst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_LIST = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.take_req = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.is_list && !sts.empty)
                begin
                    state_next = S_LIST;
                end
                else if (out_free)
                begin
                    cmd.emit_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_LIST:
            begin
                if (out_free)
                begin
                    cmd.emit_list = 1'b1;
                    if (sts.idx_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit_result || cmd.emit_list)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/sst_dpath.sv =====
// datapath of the small set table: entry registers, parallel compare, shift, result register
module sst_dpath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [1:0]                   req_kind,
    input  logic signed [sst_pkg::KEY_W-1:0] req_key,
    input  sst_pkg::cmd_t                cmd,
    output sst_pkg::sts_t                sts,
    output logic [2:0]                   out_status,
    output logic signed [sst_pkg::KEY_W-1:0] out_element,
    output logic                         out_last
);
    import sst_pkg::*;

    logic [KEY_W-1:0] entries_reg [CAPACITY];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg;
    kind_t            kind_reg;
    logic [KEY_W-1:0] key_reg;

    status_t          status_reg;
    logic [KEY_W-1:0] element_reg;
    logic             last_reg;

    logic [CAPACITY-1:0] match;
    logic [CAPACITY-1:0] shift_mask;
    logic                found;
    logic                full;
    logic                do_add;
    logic                do_remove;
    status_t             status_next;

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            match[i] = (entries_reg[i] == key_reg) && (CNT_W'(i) < count_reg);
        end
        // slot i takes the entry above it when a match lies at or below slot i
        for (int i = 0; i < CAPACITY; i++)
        begin
            shift_mask[i] = |(match << (CAPACITY - 1 - i));
        end
    end

    assign found     = |match;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign do_add    = cmd.emit_result && (kind_reg == KIND_ADD) && !found && !full;
    assign do_remove = cmd.emit_result && (kind_reg == KIND_REMOVE) && found;

    always_comb
    begin
        case (kind_reg)
            KIND_ADD:      status_next = found ? ST_PRESENT : (full ? ST_FULL : ST_ADDED);
            KIND_REMOVE:   status_next = found ? ST_REMOVED : ST_NOTFOUND;
            KIND_CONTAINS: status_next = found ? ST_FOUND : ST_NOTFOUND;
            default:       status_next = ST_EMPTY;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_add)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_remove)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign sts.is_list  = (kind_reg == KIND_LIST);
    assign sts.empty    = (count_reg == '0);
    assign sts.idx_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.take_req)
            begin
                idx_reg <= '0;
            end
            else if (cmd.emit_list)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    // table storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_remove)
        begin
            for (int i = 0; i < CAPACITY - 1; i++)
            begin
                if (shift_mask[i])
                begin
                    entries_reg[i] <= entries_reg[i + 1];
                end
            end
        end
        else if (do_add)
        begin
            entries_reg[count_reg[IDX_W-1:0]] <= key_reg;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.take_req)
        begin
            kind_reg <= kind_t'(req_kind);
            key_reg  <= req_key;
        end
        if (cmd.emit_result)
        begin
            status_reg  <= status_next;
            element_reg <= '0;
            last_reg    <= 1'b1;
        end
        else if (cmd.emit_list)
        begin
            status_reg  <= ST_ELEMENT;
            element_reg <= entries_reg[idx_reg];
            last_reg    <= sts.idx_last;
        end
    end

    assign out_status  = status_reg;
    assign out_element = element_reg;
    assign out_last    = last_reg;

endmodule

// ===== sv/small_set_table.sv =====
// top level of the small set table: a set of distinct signed 32-bit keys
//
// input channel s_*: one beat is one request; s_tuser carries the request kind
//   (add, remove, contains, list) and s_tdata carries the key
// output channel m_*: m_tuser carries the status, m_tdata the stored key on
//   element beats (zero otherwise), m_tlast marks the final beat of a request
// add, remove and contains give one beat; list gives one beat per stored entry
//   in table order, or a single empty beat when the table holds nothing
// one request is in work at a time: a request is taken in the idle state and
//   its result is loaded into the output register in the execute state once
//   the output register is free; the compare against all entries and the
//   shift of later entries on remove happen in the cycle that loads the result
// a list request passes through intake and an execute state that checks the
//   count, then reads out one entry per cycle while the output register is free
// the result goes to an output register, so the next request is taken while
//   the previous result still waits on the output side
// a stalled output holds its beat; the controller waits before loading the next
// reset empties the table (count to zero) and drops any pending beat
module small_set_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] key
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] element
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast
);
    import sst_pkg::*;

    cmd_t                    cmd;
    sts_t                    sts;
    logic signed [KEY_W-1:0] key_in;
    logic signed [KEY_W-1:0] element_out;

    assign key_in  = s_tdata;
    assign m_tdata = element_out;

    // sequencing: request intake, execute, list readout, output valid
    sst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // table, compare lanes and result payload
    sst_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_kind    (s_tuser),
        .req_key     (key_in),
        .cmd         (cmd),
        .sts         (sts),
        .out_status  (m_tuser),
        .out_element (element_out),
        .out_last    (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // only one request in work: intake closes right after a beat is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while another is in work");

    // only element beats carry data
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_ELEMENT)) |-> (m_tdata == '0))
        else $error("non-element beat with nonzero data");

    // every non-element result is the final beat of its request
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_ELEMENT)) |-> m_tlast)
        else $error("non-element beat without last");
`endif

endmodule
